FILE: rtl/pose_crossing_zone_detector_defines.svh
// Assertion macros for the pose crossing zone detector checker.
`ifndef POSE_CROSSING_ZONE_DETECTOR_DEFINES_SVH
`define POSE_CROSSING_ZONE_DETECTOR_DEFINES_SVH

// Check with reset masking.
`define PCZ_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pose crossing zone detector check failed");

// Check that also holds while reset is applied.
`define PCZ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pose crossing zone detector reset check failed");

`endif

FILE: rtl/pcz_pkg.sv
package pcz_pkg;

  localparam int COORD_BITS_DEF = 13;
  localparam int SCORE_W        = 11;
  localparam int CFG_IDX_W      = 3;
  localparam int NUM_VERT       = 4;
  localparam int KNEE_MUL       = 5;
  localparam int ANKLE_MUL      = 25;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_D        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 3'd5;

  localparam logic [2:0]         VERTEX_COUNT_RST    = 3'd4;
  localparam logic [SCORE_W-1:0] SCORE_THRESHOLD_RST = 11'd717;

  typedef struct packed {
    logic ld1;
    logic ld2;
  } pcz_load_t;

endpackage

FILE: rtl/pose_crossing_zone_detector.sv
// Channel  | Dir | Handshake          | Payload
// s_*      | in  | s_tvalid/s_tready  | s_tdata pose fields, s_tlast frame_last
// m_*      | out | m_tvalid/m_tready  | m_tdata score and box, m_tuser crossing, m_tlast
// cfg_*    | in  | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// One pose per cycle unless m_tready holds the pipeline; a pose is registered in stages v1,
// v2 and v3 in that order, and m_tvalid is the v3 valid bit.
// Depth is set by the zone test: edge differences, cross products, sign and parity.
// rst clears the stage valid bits and loads the register reset values.
// Each stage holds while the one after it is full and stalled; bubbles close up.
module pose_crossing_zone_detector #(
  parameter int COORD_BITS = pcz_pkg::COORD_BITS_DEF,
  localparam int InRaw    = pcz_pkg::SCORE_W + 12 * COORD_BITS,
  localparam int InDataW  = (InRaw + 7) / 8 * 8,
  localparam int OutRaw   = pcz_pkg::SCORE_W + 4 * COORD_BITS,
  localparam int OutDataW = (OutRaw + 7) / 8 * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // pose_score, box_left, box_top, box_right, box_bottom, left_shoulder_y,
  // right_shoulder_y, left_knee_y, right_knee_y, left_ankle_xy, right_ankle_xy
  input  logic [InDataW-1:0]             s_tdata,
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // out_score, out_left, out_top, out_right, out_bottom
  output logic [OutDataW-1:0]            m_tdata,
  // crossing
  output logic                           m_tuser,
  output logic                           m_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pcz_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [2*COORD_BITS-1:0]        cfg_data
);

  localparam int CW = COORD_BITS;
  localparam int SC = pcz_pkg::SCORE_W;
  localparam int KW = CW + 4;
  localparam int AW = CW + 6;

  logic [2*CW-1:0] vertex [pcz_pkg::NUM_VERT];
  logic            four_vertices;
  logic [SC-1:0]   score_threshold;

  logic [SC-1:0]   in_score;
  logic [CW-1:0]   in_left, in_top, in_right, in_bottom;
  logic [CW-1:0]   l_sh, r_sh, l_kn, r_kn;
  logic [2*CW-1:0] l_ank, r_ank;

  assign in_score  = s_tdata[SC-1:0];
  assign in_left   = s_tdata[SC+CW-1:SC];
  assign in_top    = s_tdata[SC+2*CW-1:SC+CW];
  assign in_right  = s_tdata[SC+3*CW-1:SC+2*CW];
  assign in_bottom = s_tdata[SC+4*CW-1:SC+3*CW];
  assign l_sh      = s_tdata[SC+5*CW-1:SC+4*CW];
  assign r_sh      = s_tdata[SC+6*CW-1:SC+5*CW];
  assign l_kn      = s_tdata[SC+7*CW-1:SC+6*CW];
  assign r_kn      = s_tdata[SC+8*CW-1:SC+7*CW];
  assign l_ank     = s_tdata[SC+10*CW-1:SC+8*CW];
  assign r_ank     = s_tdata[SC+12*CW-1:SC+10*CW];

  pcz_cfg_regs #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .vertex          (vertex),
    .four_vertices   (four_vertices),
    .score_threshold (score_threshold)
  );

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  pcz_pkg::pcz_load_t ld;

  assign rdy3     = !v3 || m_tready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign ld.ld1   = s_tvalid && rdy1;
  assign ld.ld2   = v1 && rdy2;

  logic signed [CW:0]   h;
  logic [CW-1:0]        gap_l, gap_r, gap_a;
  logic [KW-1:0]        knee_l, knee_r;
  logic signed [KW-1:0] two_h_k;
  logic [AW-1:0]        ankle_m;
  logic signed [AW-1:0] two_h_a;
  logic                 pose_ok;

  assign h     = $signed({1'b0, in_bottom}) - $signed({1'b0, in_top});
  assign gap_l = (l_kn > l_sh) ? l_kn - l_sh : l_sh - l_kn;
  assign gap_r = (r_kn > r_sh) ? r_kn - r_sh : r_sh - r_kn;
  assign gap_a = (l_ank[CW-1:0] > r_ank[CW-1:0]) ? l_ank[CW-1:0] - r_ank[CW-1:0]
                                                 : r_ank[CW-1:0] - l_ank[CW-1:0];

  assign knee_l  = KW'((KW'(gap_l) + KW'(1)) * KW'(pcz_pkg::KNEE_MUL));
  assign knee_r  = KW'((KW'(gap_r) + KW'(1)) * KW'(pcz_pkg::KNEE_MUL));
  assign two_h_k = KW'(h) <<< 1;
  assign ankle_m = AW'(AW'(gap_a) * AW'(pcz_pkg::ANKLE_MUL));
  assign two_h_a = AW'(h) <<< 1;

  assign pose_ok = (in_score >= score_threshold) &&
                   (($signed(knee_l) <= two_h_k) || ($signed(knee_r) <= two_h_k)) &&
                   ($signed(ankle_m) > two_h_a);

  logic inside_l, inside_r;

  pcz_zone #(.COORD_BITS(COORD_BITS)) u_zone_l (
    .clk           (clk),
    .ld            (ld),
    .point         (l_ank),
    .vertex        (vertex),
    .four_vertices (four_vertices),
    .in_poly       (inside_l)
  );

  pcz_zone #(.COORD_BITS(COORD_BITS)) u_zone_r (
    .clk           (clk),
    .ld            (ld),
    .point         (r_ank),
    .vertex        (vertex),
    .four_vertices (four_vertices),
    .in_poly       (inside_r)
  );

  logic [SC-1:0] score1, score2, score3;
  logic [CW-1:0] left1, top1, right1, bottom1;
  logic [CW-1:0] left2, top2, right2, bottom2;
  logic [CW-1:0] left3, top3, right3, bottom3;
  logic          last1, last2, last3;
  logic          ok1, ok2, crossing;
  logic          flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld1) begin
      score1  <= in_score;
      left1   <= in_left;
      top1    <= in_top;
      right1  <= in_right;
      bottom1 <= in_bottom;
      last1   <= s_tlast;
      ok1     <= pose_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld2) begin
      score2  <= score1;
      left2   <= left1;
      top2    <= top1;
      right2  <= right1;
      bottom2 <= bottom1;
      last2   <= last1;
      ok2     <= ok1;
    end
  end

  assign flag = ok2 && inside_l && inside_r;

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      crossing <= flag;
      score3   <= flag ? score2  : '0;
      left3    <= flag ? left2   : '0;
      top3     <= flag ? top2    : '0;
      right3   <= flag ? right2  : '0;
      bottom3  <= flag ? bottom2 : '0;
      last3    <= last2;
    end
  end

  assign m_tvalid = v3;
  assign m_tuser  = crossing;
  assign m_tlast  = last3;
  assign m_tdata  = OutDataW'({bottom3, right3, top3, left3, score3});

endmodule

FILE: rtl/pcz_cfg_regs.sv
module pcz_cfg_regs #(
  parameter int COORD_BITS = pcz_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pcz_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [2*COORD_BITS-1:0]        cfg_data,
  output logic [2*COORD_BITS-1:0]        vertex [pcz_pkg::NUM_VERT],
  output logic                           four_vertices,
  output logic [pcz_pkg::SCORE_W-1:0]    score_threshold
);

  logic [2:0] vertex_count;

  assign cfg_ready     = 1'b1;
  assign four_vertices = vertex_count[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count    <= pcz_pkg::VERTEX_COUNT_RST;
      score_threshold <= pcz_pkg::SCORE_THRESHOLD_RST;
      for (int i = 0; i < pcz_pkg::NUM_VERT; i++) begin
        vertex[i] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        pcz_pkg::REG_VERTEX_COUNT:    vertex_count    <= cfg_data[2:0];
        pcz_pkg::REG_VERTEX_A:        vertex[0]       <= cfg_data;
        pcz_pkg::REG_VERTEX_B:        vertex[1]       <= cfg_data;
        pcz_pkg::REG_VERTEX_C:        vertex[2]       <= cfg_data;
        pcz_pkg::REG_VERTEX_D:        vertex[3]       <= cfg_data;
        pcz_pkg::REG_SCORE_THRESHOLD: score_threshold <= cfg_data[pcz_pkg::SCORE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/pcz_zone.sv
module pcz_zone #(
  parameter int COORD_BITS = pcz_pkg::COORD_BITS_DEF
) (
  input  logic                     clk,
  input  pcz_pkg::pcz_load_t       ld,
  input  logic [2*COORD_BITS-1:0]  point,
  input  logic [2*COORD_BITS-1:0]  vertex [pcz_pkg::NUM_VERT],
  input  logic                     four_vertices,
  output logic                     in_poly
);

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  logic [CW-1:0] px, py;
  logic [pcz_pkg::NUM_VERT-1:0] edge_hit, edge_cross;

  assign px = point[2*CW-1:CW];
  assign py = point[CW-1:0];

  for (genvar e = 0; e < pcz_pkg::NUM_VERT; e++) begin : g_edge
    localparam int  APrev  = (e == 0) ? pcz_pkg::NUM_VERT - 2 : e - 1;
    localparam bit  Always = (e < pcz_pkg::NUM_VERT - 1);

    logic [CW-1:0] ax, ay, bx, by;
    logic skip, hit, flip, act;
    logic signed [DW-1:0] d_pay, d_bax, d_pax, d_bay;

    logic skip1, hit1, flip1, act1;
    logic signed [DW-1:0] pay1, bax1, pax1, bay1;

    logic skip2, hit2, flip2, act2;
    logic signed [PW-1:0] prod_a, prod_b;
    logic signed [SW-1:0] d;
    logic zero, pos;

    assign ax = (e == 0 && four_vertices) ? vertex[pcz_pkg::NUM_VERT-1][2*CW-1:CW]
                                          : vertex[APrev][2*CW-1:CW];
    assign ay = (e == 0 && four_vertices) ? vertex[pcz_pkg::NUM_VERT-1][CW-1:0]
                                          : vertex[APrev][CW-1:0];
    assign bx = vertex[e][2*CW-1:CW];
    assign by = vertex[e][CW-1:0];

    assign act  = Always || four_vertices;
    assign skip = (ay <= py && by <= py) || (ay > py && by > py) || (ax < px && bx < px);
    assign hit  = (py == by && px == bx) ||
                  (py == by && py == ay && ((ax <= px && px <= bx) || (bx <= px && px <= ax)));
    assign flip = by < ay;

    assign d_pay = $signed({1'b0, py}) - $signed({1'b0, ay});
    assign d_bax = $signed({1'b0, bx}) - $signed({1'b0, ax});
    assign d_pax = $signed({1'b0, px}) - $signed({1'b0, ax});
    assign d_bay = $signed({1'b0, by}) - $signed({1'b0, ay});

    always_ff @(posedge clk) begin
      if (ld.ld1) begin
        skip1 <= skip;
        hit1  <= hit;
        flip1 <= flip;
        act1  <= act;
        pay1  <= d_pay;
        bax1  <= d_bax;
        pax1  <= d_pax;
        bay1  <= d_bay;
      end
    end

    always_ff @(posedge clk) begin
      if (ld.ld2) begin
        skip2  <= skip1;
        hit2   <= hit1;
        flip2  <= flip1;
        act2   <= act1;
        prod_a <= PW'(pay1) * PW'(bax1);
        prod_b <= PW'(pax1) * PW'(bay1);
      end
    end

    assign d    = SW'(prod_a) - SW'(prod_b);
    assign zero = (d == '0);
    assign pos  = flip2 ? d[SW-1] : (!d[SW-1] && !zero);

    assign edge_hit[e]   = act2 && (skip2 ? hit2 : zero);
    assign edge_cross[e] = act2 && !skip2 && pos;
  end

  assign in_poly = (|edge_hit) || (^edge_cross);

endmodule

FILE: rtl/pcz_checker.sv
`include "pose_crossing_zone_detector_defines.svh"

module pcz_checker #(
  parameter int COORD_BITS = pcz_pkg::COORD_BITS_DEF,
  localparam int OutRaw   = pcz_pkg::SCORE_W + 4 * COORD_BITS,
  localparam int OutDataW = (OutRaw + 7) / 8 * 8
) (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                s_tlast,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata,
  input logic                m_tuser,
  input logic                m_tlast
);

  `PCZ_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid)

  `PCZ_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  `PCZ_ASSERT(a_clear_unflagged, clk, rst, m_tvalid && !m_tuser |-> m_tdata == '0)

  `PCZ_ASSERT(a_ready_when_empty, clk, rst, !m_tvalid |-> s_tready)

  `PCZ_ASSERT(a_latency, clk, rst, s_tvalid && s_tready ##1 m_tready ##1 m_tready |=> m_tvalid && (m_tlast == $past(s_tlast, 3)))

endmodule

bind pose_crossing_zone_detector pcz_checker #(.COORD_BITS(COORD_BITS)) u_pcz_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

FILE: dv/tb_pose_crossing_zone_detector.sv
module tb_pose_crossing_zone_detector;

  localparam int CFG_IDX_W = pcz_pkg::CFG_IDX_W;
  localparam int SCORE_W = pcz_pkg::SCORE_W;
  localparam int NUM_VERT = pcz_pkg::NUM_VERT;
  localparam int KNEE_MUL = pcz_pkg::KNEE_MUL;
  localparam int ANKLE_MUL = pcz_pkg::ANKLE_MUL;
  localparam logic [2:0] VERTEX_COUNT_RST = pcz_pkg::VERTEX_COUNT_RST;
  localparam logic [SCORE_W-1:0] SCORE_THRESHOLD_RST = pcz_pkg::SCORE_THRESHOLD_RST;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = pcz_pkg::REG_VERTEX_COUNT;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A = pcz_pkg::REG_VERTEX_A;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B = pcz_pkg::REG_VERTEX_B;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C = pcz_pkg::REG_VERTEX_C;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_D = pcz_pkg::REG_VERTEX_D;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = pcz_pkg::REG_SCORE_THRESHOLD;

  localparam int CB = pcz_pkg::COORD_BITS_DEF;
  localparam int COORD_MAX = (1 << CB) - 1;
  localparam int SCORE_MAX = 1024;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT = 4000;
  localparam int BLOCKS = 15;
  localparam int BLOCK_POSES = 110;

  typedef logic [2*CB-1:0] point_t;

  typedef struct packed {
    logic pad;
    point_t r_ankle, l_ankle;
    logic [CB-1:0] r_knee, l_knee, r_shoulder, l_shoulder, bottom, right, top, left;
    logic [SCORE_W-1:0] score;
  } pose_t;

  typedef struct packed {
    logic pad;
    logic [CB-1:0] bottom, right, top, left;
    logic [SCORE_W-1:0] score;
  } box_t;

  typedef struct {
    logic crossing;
    box_t box;
    logic last;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [$bits(pose_t)-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [$bits(box_t)-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [2*CB-1:0] cfg_data = '0;

  int src_idle = 29;
  int sink_idle = 52;
  int stall_cycles = 0;

  function automatic longint x_of(point_t p);
    return longint'(p[2*CB-1:CB]);
  endfunction

  function automatic longint y_of(point_t p);
    return longint'(p[CB-1:0]);
  endfunction

  function automatic longint abs_gap(longint a, longint b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic point_t to_point(longint x, longint y);
    return {x[CB-1:0], y[CB-1:0]};
  endfunction

  function automatic int pick(int lo, int hi);
    return int'($urandom_range(hi, lo));
  endfunction

  class crossing_judge;
    logic [2:0] vertex_count;
    point_t vertex[NUM_VERT];
    logic [SCORE_W-1:0] threshold;
    verdict_t awaited[$];
    int errors;

    function new();
      vertex_count = VERTEX_COUNT_RST;
      foreach (vertex[i]) vertex[i] = '0;
      threshold = SCORE_THRESHOLD_RST;
      errors = 0;
    endfunction

    function int corners();
      return (vertex_count >= 3'd4) ? 4 : 3;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [2*CB-1:0] data);
      case (idx)
        REG_VERTEX_COUNT: vertex_count = data[2:0];
        REG_VERTEX_A: vertex[0] = data;
        REG_VERTEX_B: vertex[1] = data;
        REG_VERTEX_C: vertex[2] = data;
        REG_VERTEX_D: vertex[3] = data;
        REG_SCORE_THRESHOLD: threshold = data[SCORE_W-1:0];
        default: ;
      endcase
    endfunction

    // crossing-number test; a point on an edge or vertex counts as inside
    function bit in_zone(point_t p);
      longint px, py, ax, ay, bx, by, d;
      int n;
      bit crossed;
      px = x_of(p);
      py = y_of(p);
      n = corners();
      ax = x_of(vertex[n-1]);
      ay = y_of(vertex[n-1]);
      crossed = 1'b0;
      for (int i = 0; i < n; i++) begin
        bx = x_of(vertex[i]);
        by = y_of(vertex[i]);
        if ((ay <= py && by <= py) || (ay > py && by > py) || (ax < px && bx < px)) begin
          if (py == by && (px == bx ||
              (py == ay && ((ax <= px && px <= bx) || (bx <= px && px <= ax)))))
            return 1'b1;
        end else begin
          d = (py - ay) * (bx - ax) - (px - ax) * (by - ay);
          if (d == 0)
            return 1'b1;
          if (by < ay)
            d = -d;
          if (d > 0)
            crossed = !crossed;
        end
        ax = bx;
        ay = by;
      end
      return crossed;
    endfunction

    function void note_pose(pose_t p, logic last);
      verdict_t v;
      longint h, knee_l, knee_r, ankle;
      bit flag;
      h = longint'(p.bottom) - longint'(p.top);
      knee_l = abs_gap(p.l_knee, p.l_shoulder);
      knee_r = abs_gap(p.r_knee, p.r_shoulder);
      ankle = abs_gap(y_of(p.l_ankle), y_of(p.r_ankle));
      flag = p.score >= threshold
          && (KNEE_MUL * (knee_l + 1) <= 2 * h || KNEE_MUL * (knee_r + 1) <= 2 * h)
          && ANKLE_MUL * ankle > 2 * h
          && in_zone(p.l_ankle) && in_zone(p.r_ankle);
      v.crossing = flag;
      v.box = flag ? box_t'({1'b0, p.bottom, p.right, p.top, p.left, p.score}) : '0;
      v.last = last;
      awaited = {awaited, v};
    endfunction

    function bit differs(string field, logic [31:0] want, logic [31:0] got);
      if (got === want)
        return 1'b0;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      return 1'b1;
    endfunction

    function void check_result(logic crossing, box_t box, logic last);
      verdict_t v;
      bit bad;
      if (awaited.size() == 0) begin
        $display("%0t: result transfer with no pose pending", $time);
        errors++;
        return;
      end
      v = awaited.pop_front();
      bad = differs("crossing", v.crossing, crossing);
      bad |= differs("out_score", v.box.score, box.score);
      bad |= differs("out_left", v.box.left, box.left);
      bad |= differs("out_top", v.box.top, box.top);
      bad |= differs("out_right", v.box.right, box.right);
      bad |= differs("out_bottom", v.box.bottom, box.bottom);
      bad |= differs("out_last", v.last, last);
      if (bad)
        errors++;
    endfunction
  endclass

  crossing_judge judge = new();

  pose_crossing_zone_detector u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= sink_idle);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        judge.note_pose(pose_t'(s_tdata), s_tlast);
      if (m_tvalid && m_tready)
        judge.check_result(m_tuser, box_t'(m_tdata), m_tlast);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_pose(pose_t p, logic last);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= p;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [2*CB-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    judge.write_reg(idx, data);
  endtask

  // drop the pose stream and drain every pending result
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (judge.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic pose_t make_pose(int score, int top, int bottom, int l_sh, int l_kn,
                                      int r_sh, int r_kn, point_t la, point_t ra);
    pose_t p;
    p = '0;
    p.score = SCORE_W'(score);
    p.left = CB'(300);
    p.right = CB'(900);
    p.top = CB'(top);
    p.bottom = CB'(bottom);
    p.l_shoulder = CB'(l_sh);
    p.l_knee = CB'(l_kn);
    p.r_shoulder = CB'(r_sh);
    p.r_knee = CB'(r_kn);
    p.l_ankle = la;
    p.r_ankle = ra;
    return p;
  endfunction

  function automatic point_t zone_point();
    int n, i, j, xmin, xmax, ymin, ymax;
    n = judge.corners();
    xmin = COORD_MAX;
    ymin = COORD_MAX;
    xmax = 0;
    ymax = 0;
    for (int k = 0; k < n; k++) begin
      if (x_of(judge.vertex[k]) < xmin) xmin = int'(x_of(judge.vertex[k]));
      if (x_of(judge.vertex[k]) > xmax) xmax = int'(x_of(judge.vertex[k]));
      if (y_of(judge.vertex[k]) < ymin) ymin = int'(y_of(judge.vertex[k]));
      if (y_of(judge.vertex[k]) > ymax) ymax = int'(y_of(judge.vertex[k]));
    end
    i = pick(0, n - 1);
    j = (i + 1) % n;
    case ($urandom_range(9))
      0: return point_t'($urandom);
      1, 2: return judge.vertex[i];
      3, 4: return to_point((x_of(judge.vertex[i]) + x_of(judge.vertex[j])) / 2,
                            (y_of(judge.vertex[i]) + y_of(judge.vertex[j])) / 2);
      9: return to_point(pick(xmin, xmax), y_of(judge.vertex[j]));
      default: return to_point(pick(xmin, xmax), pick(ymin, ymax));
    endcase
  endfunction

  // shoulder and knee heights whose gap sits near the knee limit for height h, below it, or at random
  function automatic logic [2*CB-1:0] knee_pair(int h);
    int gap, sh, kn;
    gap = (2 * h >= KNEE_MUL) ? (2 * h - KNEE_MUL) / KNEE_MUL : -1;
    case ($urandom_range(4))
      0: gap = gap + 1;
      1: ;
      2: gap = gap - 1;
      3: gap = pick(0, COORD_MAX);
      default: gap = (gap > 0) ? pick(0, gap) : 0;
    endcase
    if (gap < 0) gap = 0;
    if (gap > COORD_MAX) gap = COORD_MAX;
    sh = pick(0, COORD_MAX);
    kn = $urandom_range(1) ? sh + gap : sh - gap;
    if (kn > COORD_MAX) kn = sh - gap;
    if (kn < 0) kn = sh + gap;
    if (kn > COORD_MAX) kn = COORD_MAX;
    return {sh[CB-1:0], kn[CB-1:0]};
  endfunction

  function automatic pose_t craft_pose();
    pose_t p;
    int h, ag, top, sc, thr;
    logic [2*CB-1:0] side;
    p = '0;
    if ($urandom_range(9) < 2) begin
      p.score = SCORE_W'(pick(0, SCORE_MAX));
      p.left = CB'($urandom);
      p.top = CB'($urandom);
      p.right = CB'($urandom);
      p.bottom = CB'($urandom);
      p.l_shoulder = CB'($urandom);
      p.r_shoulder = CB'($urandom);
      p.l_knee = CB'($urandom);
      p.r_knee = CB'($urandom);
      p.l_ankle = point_t'($urandom);
      p.r_ankle = point_t'($urandom);
      return p;
    end
    p.l_ankle = zone_point();
    p.r_ankle = zone_point();
    ag = int'(abs_gap(y_of(p.l_ankle), y_of(p.r_ankle)));
    case ($urandom_range(7))
      0, 1, 2: h = (ANKLE_MUL * ag) / 2 + pick(0, 2) - 1;
      3, 4: h = pick(0, (ANKLE_MUL * ag) / 2);
      5: h = -pick(1, COORD_MAX);
      default: h = pick(0, COORD_MAX);
    endcase
    if (h > COORD_MAX) h = COORD_MAX;
    top = (h >= 0) ? pick(0, COORD_MAX - h) : pick(-h, COORD_MAX);
    p.top = CB'(top);
    p.bottom = CB'(top + h);
    side = knee_pair(h);
    p.l_shoulder = side[2*CB-1:CB];
    p.l_knee = side[CB-1:0];
    side = knee_pair(h);
    p.r_shoulder = side[2*CB-1:CB];
    p.r_knee = side[CB-1:0];
    p.left = CB'($urandom);
    p.right = CB'($urandom);
    thr = int'(judge.threshold);
    case ($urandom_range(5))
      0: sc = thr;
      1: sc = thr - 1;
      2: sc = pick(0, SCORE_MAX);
      default: sc = pick(thr > SCORE_MAX ? SCORE_MAX : thr, SCORE_MAX);
    endcase
    if (sc < 0) sc = 0;
    if (sc > SCORE_MAX) sc = SCORE_MAX;
    p.score = SCORE_W'(sc);
    return p;
  endfunction

  task automatic randomize_zone();
    int cx, cy, r, k;
    point_t v[NUM_VERT];
    cx = pick(600, COORD_MAX - 600);
    cy = pick(600, COORD_MAX - 600);
    r = pick(8, 500);
    case ($urandom_range(5))
      0: foreach (v[i]) v[i] = point_t'($urandom);
      1: begin
        v[0] = to_point(0, 0);
        v[1] = to_point(COORD_MAX, 0);
        v[2] = to_point(COORD_MAX, COORD_MAX);
        v[3] = to_point(0, COORD_MAX);
      end
      2: begin
        v[0] = to_point(cx - r, cy - r);
        v[1] = v[0];
        v[2] = to_point(cx + r, cy + r);
        v[3] = to_point(cx, cy);
      end
      default: begin
        v[0] = to_point(cx - pick(1, r), cy - pick(1, r));
        v[1] = to_point(cx + pick(1, r), cy - pick(1, r));
        v[2] = to_point(cx + pick(1, r), cy + pick(1, r));
        v[3] = to_point(cx - pick(1, r), cy + pick(1, r));
      end
    endcase
    if ($urandom_range(1))
      v = '{v[3], v[2], v[1], v[0]};
    k = pick(0, 7);
    program_reg(REG_VERTEX_COUNT, $urandom_range(1) ? point_t'(k) : point_t'(($urandom << 3) | k));
    program_reg(REG_VERTEX_A, v[0]);
    program_reg(REG_VERTEX_B, v[1]);
    program_reg(REG_VERTEX_C, v[2]);
    program_reg(REG_VERTEX_D, v[3]);
    case ($urandom_range(5))
      0: k = 0;
      1: k = SCORE_MAX;
      2, 3: k = pick(0, 300);
      default: k = pick(0, SCORE_MAX);
    endcase
    program_reg(REG_SCORE_THRESHOLD,
                $urandom_range(1) ? point_t'(k) : point_t'(($urandom << SCORE_W) | k));
    if ($urandom_range(3) == 0)
      program_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, point_t'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    pose_t p;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_pose('0, 1'b0);
    p = '1;
    p.pad = 1'b0;
    p.score = SCORE_W'(SCORE_MAX);
    send_pose(p, 1'b1);
    send_pose(make_pose(SCORE_MAX, 1000, 2000, 1200, 1200, 1200, 1200, '0, '0), 1'b1);

    settle();
    program_reg(REG_VERTEX_COUNT, point_t'(4));
    program_reg(REG_VERTEX_A, to_point(0, 0));
    program_reg(REG_VERTEX_B, to_point(COORD_MAX, 0));
    program_reg(REG_VERTEX_C, to_point(COORD_MAX, COORD_MAX));
    program_reg(REG_VERTEX_D, to_point(0, COORD_MAX));
    program_reg(REG_SCORE_THRESHOLD, point_t'(717));
    program_reg(REG_SPARE_LO, '1);
    program_reg(REG_SPARE_HI, '0);
    cfg_valid <= 1'b0;
    send_pose(make_pose(717, 1000, 2000, 1200, 1599, 1200, 2200,
                        to_point(100, 1900), to_point(200, 1819)), 1'b0);
    send_pose(make_pose(716, 1000, 2000, 1200, 1599, 1200, 2200,
                        to_point(100, 1900), to_point(200, 1819)), 1'b0);
    send_pose(make_pose(717, 1000, 2000, 1200, 1600, 1200, 801,
                        to_point(100, 1900), to_point(200, 1819)), 1'b1);
    send_pose(make_pose(717, 1000, 2000, 1200, 1600, 1200, 800,
                        to_point(100, 1900), to_point(200, 1819)), 1'b0);
    send_pose(make_pose(717, 1000, 2000, 1200, 1599, 1200, 1599,
                        to_point(100, 1900), to_point(200, 1820)), 1'b1);
    send_pose(make_pose(SCORE_MAX, 1000, 2000, 1200, 1200, 1200, 1200,
                        to_point(COORD_MAX, COORD_MAX), to_point(0, 5000)), 1'b0);
    send_pose(make_pose(SCORE_MAX, 2000, 1000, 1200, 1200, 1200, 1200,
                        to_point(100, 1900), to_point(200, 100)), 1'b1);
    send_pose(make_pose(SCORE_MAX, 1500, 1500, 1200, 1200, 1200, 1200,
                        to_point(100, 1900), to_point(200, 100)), 1'b0);

    settle();
    program_reg(REG_VERTEX_COUNT, point_t'(0));
    cfg_valid <= 1'b0;
    send_pose(make_pose(SCORE_MAX, 1000, 2000, 1200, 1200, 1200, 1200,
                        to_point(100, 50), to_point(4000, 3000)), 1'b1);
    send_pose(make_pose(SCORE_MAX, 1000, 2000, 1200, 1200, 1200, 1200,
                        to_point(50, 1000), to_point(4000, 3000)), 1'b0);
    send_pose(make_pose(SCORE_MAX, 1000, 2000, 1200, 1200, 1200, 1200,
                        to_point(3000, 3000), to_point(6000, 100)), 1'b1);

    settle();
    program_reg(REG_VERTEX_COUNT, '1);
    program_reg(REG_SCORE_THRESHOLD, point_t'(SCORE_MAX));
    cfg_valid <= 1'b0;
    send_pose(make_pose(SCORE_MAX, 1000, 2000, 1200, 1599, 1200, 2200,
                        to_point(100, 1900), to_point(200, 1819)), 1'b0);
    send_pose(make_pose(SCORE_MAX - 1, 1000, 2000, 1200, 1599, 1200, 2200,
                        to_point(100, 1900), to_point(200, 1819)), 1'b1);

    settle();
    program_reg(REG_SCORE_THRESHOLD, point_t'(0));
    cfg_valid <= 1'b0;
    send_pose(make_pose(0, 1000, 2000, 1200, 1599, 1200, 2200,
                        to_point(100, 1900), to_point(200, 1819)), 1'b1);

    for (int blk = 0; blk < BLOCKS; blk++) begin
      settle();
      case (blk / (BLOCKS / 3))
        0: begin
          src_idle = 29;
          sink_idle = 52;
        end
        1: begin
          src_idle = 52;
          sink_idle = 29;
        end
        default: begin
          src_idle = 0;
          sink_idle = 0;
        end
      endcase
      randomize_zone();
      repeat (BLOCK_POSES) send_pose(craft_pose(), 1'($urandom_range(1)));
    end

    settle();
    if (judge.errors == 0 && judge.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
